FILE: rtl/iwrs_pkg.sv
package iwrs_pkg;

  // Write buffer geometry
  localparam int unsigned WBUF_DEPTH = 32;
  localparam int unsigned WBUF_AW    = (WBUF_DEPTH > 1) ? $clog2(WBUF_DEPTH) : 1;
  localparam logic [8:0]  WBUF_DEPTH_W = 9'(WBUF_DEPTH);

  // Controller command bases
  localparam logic [31:0] CMD_WRITE_NOEND   = 32'h0000_2000;
  localparam logic [31:0] CMD_WRITE_AUTOEND = 32'h0200_2000;
  localparam logic [31:0] CMD_READ_AUTOEND  = 32'h0200_2400;
  localparam logic [7:0]  ADDR_MASK         = 8'hFE;

  // Request codes
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_EVENT = 2'd1,
    REQ_LOAD  = 2'd2
  } req_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_REFUSED = 3'd0,
    KIND_CMD     = 3'd1,
    KIND_TX      = 3'd2,
    KIND_RX      = 3'd3,
    KIND_DONE    = 3'd4
  } kind_e;

  // Session error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_ARB  = 2'd1;
  localparam logic [1:0] ERR_NACK = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_DEV_ADDR = 3'd0;
  localparam logic [2:0] CFG_OP_LEN   = 3'd1;
  localparam logic [2:0] CFG_OP_VAL   = 3'd2;
  localparam logic [2:0] CFG_WR_LEN   = 3'd3;
  localparam logic [2:0] CFG_RD_LEN   = 3'd4;

  // Pending-result mask, bit order is emission order
  localparam int unsigned NUM_RES     = 5;
  localparam int unsigned RES_REFUSED = 0;
  localparam int unsigned RES_DONE    = 1;
  localparam int unsigned RES_CMD     = 2;
  localparam int unsigned RES_TX      = 3;
  localparam int unsigned RES_RX      = 4;

  typedef logic [NUM_RES-1:0] res_mask_t;

  // One decoded item waiting for emission
  typedef struct packed {
    res_mask_t   mask;
    logic [31:0] cmd;
    logic [1:0]  err;
    logic [7:0]  rx_index;
    logic [7:0]  rx_byte;
    logic        tx_mem;
    logic [7:0]  tx_imm;
  } item_t;

  // Write buffer access
  typedef struct packed {
    logic               re;
    logic [WBUF_AW-1:0] raddr;
    logic               we;
    logic [WBUF_AW-1:0] waddr;
    logic [7:0]         wdata;
  } wbuf_req_t;

  function automatic logic [31:0] make_cmd(logic [7:0] addr, logic [31:0] base,
                                           logic [7:0] count);
    make_cmd = 32'(addr & ADDR_MASK) | base | (32'(count) << 16);
  endfunction

endpackage

FILE: rtl/iwrs_if.sv
interface iwrs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       flag_arbitration_lost;
  logic       flag_nack;
  logic       flag_stop;
  logic       flag_transfer_complete;
  logic       flag_tx_ready;
  logic       flag_rx_ready;
  logic [7:0] received_byte;
  logic [4:0] load_index;
  logic [7:0] load_byte;

  modport source (output valid, req_type, flag_arbitration_lost, flag_nack, flag_stop,
                  flag_transfer_complete, flag_tx_ready, flag_rx_ready, received_byte,
                  load_index, load_byte, input ready);
  modport sink (input valid, req_type, flag_arbitration_lost, flag_nack, flag_stop,
                flag_transfer_complete, flag_tx_ready, flag_rx_ready, received_byte,
                load_index, load_byte, output ready);
endinterface

interface iwrs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] command_word;
  logic [7:0]  tx_byte;
  logic [7:0]  rx_index;
  logic [7:0]  rx_byte;
  logic [1:0]  session_error;
  logic        last;

  modport source (output valid, kind, command_word, tx_byte, rx_index, rx_byte,
                  session_error, last, input ready);
  modport sink (input valid, kind, command_word, tx_byte, rx_index, rx_byte,
                session_error, last, output ready);
endinterface

FILE: rtl/i2c_write_read_sequencer.sv
// Write-then-read session sequencer for an I2C bus controller.
// in_i takes words: start a session, a set of controller event flags, or a
// write buffer load. out_o gives result words: start refused, command word,
// transmit byte, received byte, session done; last marks the final result of
// a word. Registers are written on cfg_we_i; the user must do so only while
// the block is idle, as the block does not enforce it. The accept edge loads
// a word into the item register, and the output register then takes its
// first result unless stalled. Throughput: one word per cycle when each
// yields at most one result and the receiver does not stall; a word with
// more results holds the item register until its last result leaves, as the
// output register takes one result a cycle unless stalled. The write buffer
// is a 1R1W memory read and written at the accept edge, so back-to-back load
// and transmit need no forwarding. Reset clears session state, configuration
// and both pipeline valids; the buffer holds no reset value and needs no
// clearing pass. When the receiver stalls, the output register holds its
// word and the item register keeps one word waiting; in_i.ready then drops.
module i2c_write_read_sequencer
  import iwrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  iwrs_in_if.sink     in_i,
  iwrs_out_if.source  out_o
);

  logic      accept;
  logic      in_ready;
  item_t     item;
  wbuf_req_t wbuf_req;
  logic [7:0] rd_data;

  iwrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .in_ready_i  (in_ready),
    .accept_o    (accept),
    .item_o      (item),
    .wbuf_o      (wbuf_req)
  );

  iwrs_wbuf u_wbuf (
    .clk_i     (clk_i),
    .req_i     (wbuf_req),
    .rd_data_o (rd_data)
  );

  iwrs_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item),
    .rd_data_i  (rd_data),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

endmodule

FILE: rtl/iwrs_wbuf.sv
module iwrs_wbuf
  import iwrs_pkg::*;
(
  input  logic      clk_i,
  input  wbuf_req_t req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem_q [WBUF_DEPTH];
  logic [7:0] rd_data_q;

  // Single write port, registered read port; read data holds until next read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/iwrs_ctrl.sv
module iwrs_ctrl
  import iwrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  iwrs_in_if.sink     in_i,
  input  logic        in_ready_i,
  output logic        accept_o,
  output item_t       item_o,
  output wbuf_req_t   wbuf_o
);

  logic [7:0]  dev_addr_q;
  logic [2:0]  op_len_q;
  logic [31:0] op_val_q;
  logic [7:0]  wr_len_q;
  logic [7:0]  rd_len_q;

  logic       busy_q, busy_d;
  logic [7:0] idx_q, idx_d;
  logic [1:0] err_q, err_d;

  logic       accept;
  logic [7:0] wlen;
  logic [7:0] idx_t;
  logic [1:0] err_t;
  logic [7:0] tx_pos;
  logic [7:0] buf_pos;
  logic [8:0] buf_pos_w;
  logic [8:0] load_w;
  logic [2:0] back;

  assign in_i.ready = in_ready_i;
  assign accept     = in_i.valid & in_ready_i;
  assign accept_o   = accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
      op_len_q   <= '0;
      op_val_q   <= '0;
      wr_len_q   <= '0;
      rd_len_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEV_ADDR: dev_addr_q <= cfg_data_i[7:0];
        CFG_OP_LEN:   op_len_q   <= cfg_data_i[2:0];
        CFG_OP_VAL:   op_val_q   <= cfg_data_i;
        CFG_WR_LEN:   wr_len_q   <= cfg_data_i[7:0];
        CFG_RD_LEN:   rd_len_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign wlen = 8'(op_len_q) + wr_len_q;

  // Decode one word into pending results and next session state
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    err_d  = err_q;
    idx_t  = idx_q;
    err_t  = err_q;
    tx_pos = '0;
    item_o = '0;
    case (req_e'(in_i.req_type))
      REQ_START: begin
        if (busy_q) begin
          item_o.mask[RES_REFUSED] = 1'b1;
        end else begin
          busy_d = 1'b1;
          idx_d  = '0;
          err_d  = ERR_NONE;
          item_o.mask[RES_CMD] = 1'b1;
          if (wlen != 8'd0) begin
            item_o.cmd = make_cmd(dev_addr_q,
                                  (rd_len_q == 8'd0) ? CMD_WRITE_AUTOEND : CMD_WRITE_NOEND,
                                  wlen);
          end else begin
            item_o.cmd = make_cmd(dev_addr_q, CMD_READ_AUTOEND, rd_len_q);
          end
        end
      end
      REQ_EVENT: begin
        if (in_i.flag_arbitration_lost) err_t = ERR_ARB;
        if (in_i.flag_nack)             err_t = ERR_NACK;
        err_d = err_t;
        if (in_i.flag_stop && busy_q) begin
          busy_d = 1'b0;
          item_o.mask[RES_DONE] = 1'b1;
          item_o.err = err_t;
        end
        if (in_i.flag_transfer_complete) begin
          idx_t = '0;
          item_o.mask[RES_CMD] = 1'b1;
          item_o.cmd = make_cmd(dev_addr_q, CMD_READ_AUTOEND, rd_len_q);
        end
        if (in_i.flag_tx_ready) begin
          tx_pos = idx_t;
          idx_t  = idx_t + 8'd1;
          item_o.mask[RES_TX] = 1'b1;
        end
        if (in_i.flag_rx_ready) begin
          item_o.rx_index = idx_t;
          item_o.rx_byte  = in_i.received_byte;
          idx_t = idx_t + 8'd1;
          item_o.mask[RES_RX] = 1'b1;
        end
        idx_d = idx_t;
      end
      default: ;
    endcase

    // Transmit source: opcode byte, buffer entry or zero
    back = op_len_q - tx_pos[2:0] - 3'd1;
    if (tx_pos < 8'(op_len_q)) begin
      item_o.tx_imm = back[2] ? 8'd0 : 8'(op_val_q >> {back[1:0], 3'b000});
    end else begin
      item_o.tx_mem = (buf_pos_w < WBUF_DEPTH_W);
    end
  end

  assign buf_pos   = tx_pos - 8'(op_len_q);
  assign buf_pos_w = 9'(buf_pos);
  assign load_w    = 9'(in_i.load_index);

  // Buffer port: load writes, transmit reads, both at the accept edge
  always_comb begin
    wbuf_o.re    = accept && (req_e'(in_i.req_type) == REQ_EVENT) && item_o.tx_mem
                   && in_i.flag_tx_ready;
    wbuf_o.raddr = buf_pos_w[WBUF_AW-1:0];
    wbuf_o.we    = accept && (req_e'(in_i.req_type) == REQ_LOAD) && (load_w < WBUF_DEPTH_W);
    wbuf_o.waddr = load_w[WBUF_AW-1:0];
    wbuf_o.wdata = in_i.load_byte;
  end

  // Session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      err_q  <= ERR_NONE;
    end else if (accept) begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      err_q  <= err_d;
    end
  end

endmodule

FILE: rtl/iwrs_emit.sv
module iwrs_emit
  import iwrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  item_t      item_i,
  input  logic [7:0] rd_data_i,
  output logic       in_ready_o,
  iwrs_out_if.source out_o
);

  item_t     item_q;
  res_mask_t sel;
  res_mask_t rest;
  logic      take;
  logic      move;
  logic      sel_last;

  logic        out_valid_q;
  logic [2:0]  kind_q;
  logic [31:0] cmd_q;
  logic [7:0]  tx_q;
  logic [7:0]  rx_idx_q;
  logic [7:0]  rx_byte_q;
  logic [1:0]  err_q;
  logic        last_q;

  // Lowest pending result goes next
  assign sel      = item_q.mask & (~item_q.mask + res_mask_t'(1));
  assign rest     = item_q.mask & ~sel;
  assign sel_last = (rest == '0);
  assign take     = ~out_valid_q | out_o.ready;
  assign move     = (item_q.mask != '0) & take;
  assign in_ready_o = (item_q.mask == '0) | (move & sel_last);

  // Item register: whole word on accept, pending mask shrinks as results leave
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (accept_i) begin
      item_q <= item_i;
    end else if (move) begin
      item_q.mask <= rest;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      kind_q    <= KIND_REFUSED;
      cmd_q     <= '0;
      tx_q      <= '0;
      rx_idx_q  <= '0;
      rx_byte_q <= '0;
      err_q     <= ERR_NONE;
      last_q    <= sel_last;
      case (sel)
        res_mask_t'(1 << RES_REFUSED): kind_q <= KIND_REFUSED;
        res_mask_t'(1 << RES_DONE): begin
          kind_q <= KIND_DONE;
          err_q  <= item_q.err;
        end
        res_mask_t'(1 << RES_CMD): begin
          kind_q <= KIND_CMD;
          cmd_q  <= item_q.cmd;
        end
        res_mask_t'(1 << RES_TX): begin
          kind_q <= KIND_TX;
          tx_q   <= item_q.tx_mem ? rd_data_i : item_q.tx_imm;
        end
        res_mask_t'(1 << RES_RX): begin
          kind_q    <= KIND_RX;
          rx_idx_q  <= item_q.rx_index;
          rx_byte_q <= item_q.rx_byte;
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = kind_q;
  assign out_o.command_word  = cmd_q;
  assign out_o.tx_byte       = tx_q;
  assign out_o.rx_index      = rx_idx_q;
  assign out_o.rx_byte       = rx_byte_q;
  assign out_o.session_error = err_q;
  assign out_o.last          = last_q;

endmodule

FILE: rtl/iwrs_chk.sv
module iwrs_chk
  import iwrs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [31:0] out_cmd,
  input logic [7:0]  out_tx,
  input logic [7:0]  out_rx_idx,
  input logic [7:0]  out_rx_byte,
  input logic        out_last
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_cmd))
    else $error("result word changed under stall");

  // A refused start yields exactly one result
  a_refused_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_REFUSED |-> out_last)
    else $error("refused start not marked last");

  // Command field only carries a command result
  a_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != KIND_CMD |-> out_cmd == '0)
    else $error("command word leaked into other result");

  // Received fields only on received results
  a_rx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != KIND_RX |-> out_rx_idx == '0 && out_rx_byte == '0)
    else $error("received fields leaked into other result");

  // Transmit byte only on transmit results
  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != KIND_TX |-> out_tx == '0)
    else $error("transmit byte leaked into other result");

endmodule

bind i2c_write_read_sequencer iwrs_chk u_iwrs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_kind    (out_o.kind),
  .out_cmd     (out_o.command_word),
  .out_tx      (out_o.tx_byte),
  .out_rx_idx  (out_o.rx_index),
  .out_rx_byte (out_o.rx_byte),
  .out_last    (out_o.last)
);

FILE: tb/sv/session_checker.sv
module session_checker
  import iwrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  iwrs_in_if          in_mon,
  iwrs_out_if         out_mon,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] cmd;
    logic [7:0]  tx;
    logic [7:0]  rx_idx;
    logic [7:0]  rx_byte;
    logic [1:0]  err;
    logic        last;
  } session_result_t;

  // Register copies
  logic [7:0]  dev_addr;
  logic [2:0]  op_len;
  logic [31:0] op_val;
  logic [7:0]  wr_len;
  logic [7:0]  rd_len;

  // Session state
  logic        sess_busy;
  logic [7:0]  byte_pos;
  logic [1:0]  err_code;
  logic [7:0]  write_buf [WBUF_DEPTH];

  session_result_t due_results[$];

  function automatic logic [31:0] command_word_for(input logic [31:0] base,
                                                   input logic [7:0] count);
    return {24'd0, dev_addr & ADDR_MASK} | base | {8'd0, count, 16'd0};
  endfunction

  // Opcode bytes go out MSB first, then buffer bytes; opcode bytes above bit 31 and anything past the buffer are zero
  function automatic logic [7:0] tx_byte_at(input logic [7:0] pos);
    int unsigned p, ol, back, bi;
    p  = pos;
    ol = op_len;
    if (p < ol) begin
      back = ol - p - 1;
      if (back >= 4) return 8'h00;
      return 8'(op_val >> (back * 8));
    end
    bi = p - ol;
    if (bi < WBUF_DEPTH) return write_buf[bi];
    return 8'h00;
  endfunction

  function automatic session_result_t make_result(input kind_e k, input logic [31:0] cmd,
                                                  input logic [7:0] tx, input logic [7:0] ri,
                                                  input logic [7:0] rb, input logic [1:0] err);
    session_result_t r;
    r.kind    = k;
    r.cmd     = cmd;
    r.tx      = tx;
    r.rx_idx  = ri;
    r.rx_byte = rb;
    r.err     = err;
    r.last    = 1'b0;
    return r;
  endfunction

  // Work out the results of one accepted input word and update the session
  function automatic void predict_controller_word();
    session_result_t res [4];
    int              n;
    logic [7:0]      wlen;
    n = 0;
    case (in_mon.req_type)
      REQ_START: begin
        if (sess_busy) begin
          res[n] = make_result(KIND_REFUSED, '0, '0, '0, '0, ERR_NONE);
          n++;
        end else begin
          wlen      = {5'd0, op_len} + wr_len;
          sess_busy = 1'b1;
          byte_pos  = 8'd0;
          err_code  = ERR_NONE;
          if (wlen != 8'd0)
            res[n] = make_result(KIND_CMD, command_word_for(
                       (rd_len == 8'd0) ? CMD_WRITE_AUTOEND : CMD_WRITE_NOEND, wlen),
                       '0, '0, '0, ERR_NONE);
          else
            res[n] = make_result(KIND_CMD, command_word_for(CMD_READ_AUTOEND, rd_len),
                                 '0, '0, '0, ERR_NONE);
          n++;
        end
      end
      REQ_EVENT: begin
        // fixed order: arb, nack, stop, transfer complete, tx, rx; NACK overrides arb
        if (in_mon.flag_arbitration_lost) err_code = ERR_ARB;
        if (in_mon.flag_nack) err_code = ERR_NACK;
        if (in_mon.flag_stop && sess_busy) begin
          sess_busy = 1'b0;
          res[n] = make_result(KIND_DONE, '0, '0, '0, '0, err_code);
          n++;
        end
        if (in_mon.flag_transfer_complete) begin
          byte_pos = 8'd0;
          res[n] = make_result(KIND_CMD, command_word_for(CMD_READ_AUTOEND, rd_len),
                               '0, '0, '0, ERR_NONE);
          n++;
        end
        if (in_mon.flag_tx_ready) begin
          res[n] = make_result(KIND_TX, '0, tx_byte_at(byte_pos), '0, '0, ERR_NONE);
          byte_pos = byte_pos + 8'd1;
          n++;
        end
        if (in_mon.flag_rx_ready) begin
          res[n] = make_result(KIND_RX, '0, '0, byte_pos, in_mon.received_byte, ERR_NONE);
          byte_pos = byte_pos + 8'd1;
          n++;
        end
      end
      REQ_LOAD: begin
        if (in_mon.load_index < WBUF_DEPTH) write_buf[in_mon.load_index] = in_mon.load_byte;
      end
      default: ;
    endcase
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) due_results.push_back(res[i]);
  endfunction

  // Compare one accepted result word with the oldest prediction
  function automatic void check_result_word();
    session_result_t want;
    session_result_t got;
    got = make_result(kind_e'(out_mon.kind), out_mon.command_word, out_mon.tx_byte,
                      out_mon.rx_index, out_mon.rx_byte, out_mon.session_error);
    got.last = out_mon.last;
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result word: kind=%0d cmd=%h tx=%h idx=%0d rx=%h err=%0d last=%b",
                 got.kind, got.cmd, got.tx, got.rx_idx, got.rx_byte, got.err, got.last);
      return;
    end
    want = due_results.pop_front();
    if (want.kind != got.kind || want.cmd != got.cmd || want.tx != got.tx ||
        want.rx_idx != got.rx_idx || want.rx_byte != got.rx_byte ||
        want.err != got.err || want.last != got.last) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("result mismatch: expected kind=%0d cmd=%h tx=%h idx=%0d rx=%h err=%0d last=%b",
                 want.kind, want.cmd, want.tx, want.rx_idx, want.rx_byte, want.err, want.last);
        $display("                 actual   kind=%0d cmd=%h tx=%h idx=%0d rx=%h err=%0d last=%b",
                 got.kind, got.cmd, got.tx, got.rx_idx, got.rx_byte, got.err, got.last);
      end
    end
  endfunction

  // Sample both channels and the register port at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr      = '0;
      op_len        = '0;
      op_val        = '0;
      wr_len        = '0;
      rd_len        = '0;
      sess_busy     = 1'b0;
      byte_pos      = '0;
      err_code      = ERR_NONE;
      fail_count    = 0;
      pending_count = 0;
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEV_ADDR: dev_addr = cfg_data_i[7:0];
          CFG_OP_LEN:   op_len   = cfg_data_i[2:0];
          CFG_OP_VAL:   op_val   = cfg_data_i;
          CFG_WR_LEN:   wr_len   = cfg_data_i[7:0];
          CFG_RD_LEN:   rd_len   = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_controller_word();
      if (out_mon.valid && out_mon.ready) check_result_word();
      pending_count = due_results.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import iwrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  REQ_UNUSED    = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_WORDS  = 24;
  localparam int unsigned PHASE_WORDS   = 8;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned SEQ_CAP       = 16;
  localparam int unsigned WRAP_WORDS    = 130;

  typedef struct {
    logic [1:0] req;
    logic       arb;
    logic       nack;
    logic       stop;
    logic       tc;
    logic       tx;
    logic       rx;
    logic [7:0] rbyte;
    logic [4:0] lidx;
    logic [7:0] lbyte;
  } word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  int          fail_count;
  int          pending_count;

  int unsigned cycle_cnt   = 0;
  int unsigned stall_phase = 0;
  int unsigned words_sent;
  int unsigned burst_left;

  // Register values as last written, used to shape sessions
  logic [2:0]  cur_oplen;
  logic [7:0]  cur_wrlen;
  logic [7:0]  cur_rdlen;

  iwrs_in_if  in_if ();
  iwrs_out_if out_if ();

  i2c_write_read_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  session_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #5ns;
    clk_i = 1'b1;
    #5ns;
  end

  // Receiver stalls: the pattern steps through five stretches in turn, one of them always ready
  always @(negedge clk_i) begin
    stall_phase++;
    case ((stall_phase / 97) % 5)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= 1'($urandom_range(0, 1));
      2:       out_if.ready <= 1'($urandom_range(0, 3) != 0);
      3:       out_if.ready <= 1'((stall_phase % 5) != 0);
      default: out_if.ready <= 1'((stall_phase % 16) >= 5);
    endcase
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Unused fields carry random junk so every bit toggles
  function automatic word_t blank_word(input logic [1:0] req);
    word_t w;
    w.req   = req;
    w.arb   = 1'b0;
    w.nack  = 1'b0;
    w.stop  = 1'b0;
    w.tc    = 1'b0;
    w.tx    = 1'b0;
    w.rx    = 1'b0;
    w.rbyte = 8'($urandom);
    w.lidx  = 5'($urandom);
    w.lbyte = 8'($urandom);
    return w;
  endfunction

  function automatic word_t event_word(input bit arb, input bit nack, input bit stop,
                                       input bit tc, input bit tx, input bit rx);
    word_t w;
    w      = blank_word(REQ_EVENT);
    w.arb  = arb;
    w.nack = nack;
    w.stop = stop;
    w.tc   = tc;
    w.tx   = tx;
    w.rx   = rx;
    return w;
  endfunction

  function automatic word_t load_word(input logic [4:0] idx, input logic [7:0] val);
    word_t w;
    w       = blank_word(REQ_LOAD);
    w.lidx  = idx;
    w.lbyte = val;
    return w;
  endfunction

  function automatic word_t noise_word();
    word_t w;
    w      = blank_word(2'($urandom));
    w.arb  = 1'($urandom_range(0, 3) == 0);
    w.nack = 1'($urandom_range(0, 3) == 0);
    w.stop = 1'($urandom_range(0, 3) == 0);
    w.tc   = 1'($urandom_range(0, 3) == 0);
    w.tx   = 1'($urandom_range(0, 1));
    w.rx   = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Drive one word at the falling edge, hold until accepted; bursts with gaps
  task automatic send_word(input word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    @(negedge clk_i);
    in_if.valid                  <= 1'b1;
    in_if.req_type               <= w.req;
    in_if.flag_arbitration_lost  <= w.arb;
    in_if.flag_nack              <= w.nack;
    in_if.flag_stop              <= w.stop;
    in_if.flag_transfer_complete <= w.tc;
    in_if.flag_tx_ready          <= w.tx;
    in_if.flag_rx_ready          <= w.rx;
    in_if.received_byte          <= w.rbyte;
    in_if.load_index             <= w.lidx;
    in_if.load_byte              <= w.lbyte;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
    if (w.req != REQ_UNUSED) words_sent++;
  endtask

  // Hold off until every predicted result has come, then let the pipe empty
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_OP_LEN: cur_oplen = val[2:0];
      CFG_WR_LEN: cur_wrlen = val[7:0];
      CFG_RD_LEN: cur_rdlen = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [2:0] oplen,
                            input logic [31:0] opval, input logic [7:0] wrlen,
                            input logic [7:0] rdlen);
    drain_results();
    write_reg(CFG_DEV_ADDR, {24'd0, addr});
    write_reg(CFG_OP_LEN, {29'd0, oplen});
    write_reg(CFG_OP_VAL, opval);
    write_reg(CFG_WR_LEN, {24'd0, wrlen});
    write_reg(CFG_RD_LEN, {24'd0, rdlen});
  endtask

  // Mostly short transfers, some medium, a few near the top of the range
  function automatic logic [7:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'($urandom_range(0, 6));
    if (r < 85) return 8'($urandom_range(7, 40));
    return 8'($urandom_range(250, 255));
  endfunction

  task automatic random_config();
    logic [7:0]  addr;
    logic [31:0] opv;
    logic [2:0]  oplen;
    addr  = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00)
                                        : 8'($urandom);
    opv   = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0)
                                        : $urandom;
    oplen = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    set_config(addr, oplen, opv, pick_len(), pick_len());
  endtask

  // One well-formed session: start, write bytes, read bytes, stop; long ones cut short by NACK
  task automatic run_session();
    logic [7:0]  wl;
    int unsigned ntx, nrx, r;
    bit          cut, arb, nack;
    wl  = {5'd0, cur_oplen} + cur_wrlen;
    cut = 1'b0;
    if ($urandom_range(0, 9) == 0) send_word(noise_word());
    send_word(blank_word(REQ_START));
    if ($urandom_range(0, 9) == 0) send_word(blank_word(REQ_START));
    ntx = wl;
    if (ntx > SEQ_CAP) begin
      ntx = $urandom_range(1, SEQ_CAP);
      cut = 1'b1;
    end
    for (int i = 0; i < ntx; i++) begin
      send_word(event_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      if ($urandom_range(0, 19) == 0) send_word(noise_word());
    end
    if (!cut && cur_rdlen != 8'd0) begin
      if (wl != 8'd0) send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      nrx = cur_rdlen;
      if (nrx > SEQ_CAP) begin
        nrx = $urandom_range(1, SEQ_CAP);
        cut = 1'b1;
      end
      for (int i = 0; i < nrx; i++) begin
        send_word(event_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        if ($urandom_range(0, 19) == 0) send_word(load_word(5'($urandom), 8'($urandom)));
      end
    end
    r    = $urandom_range(0, 99);
    arb  = (r >= 85);
    nack = cut || (r >= 70 && r < 80) || (r >= 95);
    if ((arb || nack) && $urandom_range(0, 1) != 0) begin
      send_word(event_word(arb, nack, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    end else begin
      send_word(event_word(arb, nack, 1'b1, 1'b0, 1'b0, 1'b0));
    end
  endtask

  initial begin
    int unsigned random_base;
    int unsigned phase_base;
    word_t       w;
    rst_ni                       = 1'b0;
    cfg_we_i                     = 1'b0;
    cfg_index_i                  = CFG_DEV_ADDR;
    cfg_data_i                   = '0;
    in_if.valid                  = 1'b0;
    in_if.req_type               = REQ_START;
    in_if.flag_arbitration_lost  = 1'b0;
    in_if.flag_nack              = 1'b0;
    in_if.flag_stop              = 1'b0;
    in_if.flag_transfer_complete = 1'b0;
    in_if.flag_tx_ready          = 1'b0;
    in_if.flag_rx_ready          = 1'b0;
    in_if.received_byte          = '0;
    in_if.load_index             = '0;
    in_if.load_byte              = '0;
    out_if.ready                 = 1'b0;
    words_sent                   = 0;
    burst_left                   = 0;
    cur_oplen                    = '0;
    cur_wrlen                    = '0;
    cur_rdlen                    = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill the whole write buffer so no transmit reads an unloaded entry
    for (int i = 0; i < WBUF_DEPTH; i++)
      send_word(load_word(5'(i), (i == 0) ? 8'hFF : (i == WBUF_DEPTH - 1) ? 8'h00
                                                                           : 8'($urandom)));

    // Reset settings: nothing to write, so an empty auto-end read
    send_word(blank_word(REQ_START));
    send_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));

    // Write-then-read session with opcode and buffer bytes
    set_config(8'hFF, 3'd2, 32'hA1B2_C3D4, 8'd3, 8'd2);
    send_word(blank_word(REQ_START));
    send_word(blank_word(REQ_START));
    repeat (5) send_word(event_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    w = event_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    w.rbyte = 8'h00;
    send_word(w);
    w.rbyte = 8'hFF;
    send_word(w);
    send_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    // stop while idle, unused request, every flag while idle
    send_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(blank_word(REQ_UNUSED));
    send_word(event_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    // every flag in session: both errors, NACK wins, four results
    send_word(blank_word(REQ_START));
    send_word(event_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(blank_word(REQ_START));
    send_word(event_word(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));

    // Opcode wider than 32 bits and a write length that wraps
    set_config(8'h00, 3'd7, 32'hFFFF_FFFF, 8'd255, 8'd0);
    send_word(blank_word(REQ_START));
    repeat (8) send_word(event_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));

    // Read-only session of maximum length, ended by NACK
    set_config(8'h5A, 3'd0, 32'h0, 8'd0, 8'd255);
    send_word(blank_word(REQ_START));
    repeat (2) send_word(event_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_word(event_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));

    // Random sessions under changing settings
    random_base = words_sent;
    while (words_sent - random_base < RANDOM_WORDS) begin
      random_config();
      phase_base = words_sent;
      while (words_sent - phase_base < PHASE_WORDS) begin
        run_session();
        if ($urandom_range(0, 5) == 0) drain_results();
        if ($urandom_range(0, 7) == 0) send_word(noise_word());
      end
    end

    // Long session with tx and rx together so the byte index wraps
    set_config(8'($urandom), 3'd1, $urandom, 8'd10, 8'd3);
    send_word(blank_word(REQ_START));
    repeat (WRAP_WORDS) send_word(event_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));

    drain_results();
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/iwrs_pkg.sv
rtl/iwrs_if.sv
rtl/iwrs_wbuf.sv
rtl/iwrs_ctrl.sv
rtl/iwrs_emit.sv
rtl/i2c_write_read_sequencer.sv
rtl/iwrs_chk.sv
tb/sv/session_checker.sv
tb/sv/tb_top.sv
